>>> rtl/tnsg_pkg.sv
// ----------------------------------------------------------------------------
// tnsg_pkg
// Shared types, constants and functions of the tone and noise sample
// generator: configuration record, register indexes, LFSR step and the
// fixed-point cosine table builder.
// ----------------------------------------------------------------------------
package tnsg_pkg;

   // Default geometry
   localparam int PHASE_BITS_DEF     = 16;
   localparam int COS_TABLE_BITS_DEF = 10;
   localparam int QUEUE_DEPTH        = 4;

   // Configuration port geometry
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_STEP    = 3'd0,
      CSR_TONE_GAIN     = 3'd1,
      CSR_NOISE_GAIN    = 3'd2,
      CSR_SILENCE_NOISE = 3'd3,
      CSR_TONE_OFFSET   = 3'd4,
      CSR_FORMAT_FLAGS  = 3'd5
   } csr_index_type;

   // Reset values
   localparam logic [15:0] PHASE_STEP_RST    = 16'd1486;
   localparam logic [14:0] TONE_GAIN_RST     = 15'd76;
   localparam logic [14:0] NOISE_GAIN_RST    = 15'd0;
   localparam logic [14:0] SILENCE_NOISE_RST = 15'd0;
   localparam logic [14:0] TONE_OFFSET_RST   = 15'd0;
   localparam logic [1:0]  FORMAT_FLAGS_RST  = 2'd2;
   localparam logic [15:0] LFSR_SEED         = 16'hACE1;
   localparam logic [15:0] LFSR_TAPS         = 16'hB400;

   // Format flag bit positions
   localparam int FMT_WIDE_BIT = 0;
   localparam int FMT_BIG_BIT  = 1;

   // Fixed-point constants for the cosine builder
   localparam longint Q30_ONE     = 64'sd1 << 30;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   // Configuration record
   typedef struct packed {
      logic [15:0] phase_step;
      logic [14:0] tone_gain;
      logic [14:0] noise_gain;
      logic [14:0] silence_noise;
      logic [14:0] tone_offset;
      logic [1:0]  format_flags;
   } cfg_type;

   // One step of the right-shifting Galois LFSR
   function automatic logic [15:0] lfsr_next(input logic [15:0] l);
      logic [15:0] s;
      s = l >> 1;
      if (l[0]) begin
         s = s ^ LFSR_TAPS;
      end
      return s;
   endfunction

   // Q30 product with truncating shift
   function automatic longint q30_mul(input longint a, input longint b);
      logic [63:0] p;
      p = $unsigned(a) * $unsigned(b);
      return longint'(p >> 30);
   endfunction

   // Quarter-wave magnitude in Q15 (0..32768) for quadrant offset r.
   // Truncated Taylor series, evaluated at elaboration only.
   function automatic logic [15:0] quarter_mag(input int r, input int ctb,
                                               input logic want_sin);
      longint x;
      longint a;
      longint a2;
      longint s;
      longint c;
      longint v;
      x  = longint'(r) << (30 - (ctb - 2));
      a  = q30_mul(x, HALF_PI_Q30);
      a2 = q30_mul(a, a);

      s = Q30_ONE - a2 / 72;
      s = Q30_ONE - q30_mul(a2, s) / 42;
      s = Q30_ONE - q30_mul(a2, s) / 20;
      s = Q30_ONE - q30_mul(a2, s) / 6;
      s = q30_mul(a, s);

      c = Q30_ONE - a2 / 56;
      c = Q30_ONE - q30_mul(a2, c) / 30;
      c = Q30_ONE - q30_mul(a2, c) / 12;
      c = Q30_ONE - q30_mul(a2, c) / 2;

      v = want_sin ? s : c;
      if (v < 0) begin
         v = 0;
      end
      if (v > Q30_ONE) begin
         v = Q30_ONE;
      end
      v = (v + (64'sd1 << 14)) >>> 15;
      return v[15:0];
   endfunction

endpackage

>>> rtl/tnsg_req_if.sv
// ----------------------------------------------------------------------------
// tnsg_req_if
// Tick request channel: one request per audio sample.
// ----------------------------------------------------------------------------
interface tnsg_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic burst_start;

   modport source (output valid, output mode, output burst_start, input ready);
   modport sink   (input valid, input mode, input burst_start, output ready);
endinterface

>>> rtl/tnsg_rsp_if.sv
// ----------------------------------------------------------------------------
// tnsg_rsp_if
// Sample byte channel: one beat per byte of a sample.
// ----------------------------------------------------------------------------
interface tnsg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample_byte;
   logic       last_byte;

   modport source (output valid, output sample_byte, output last_byte, input ready);
   modport sink   (input valid, input sample_byte, input last_byte, output ready);
endinterface

>>> rtl/tnsg_front.sv
// ----------------------------------------------------------------------------
// tnsg_front
// Front end: accepts tick requests, runs the noise LFSR and the phase
// accumulator, and pushes one work entry {silent, noise draw, table index}.
// ----------------------------------------------------------------------------
module tnsg_front #(
   parameter int PHASE_BITS     = tnsg_pkg::PHASE_BITS_DEF,
   parameter int COS_TABLE_BITS = tnsg_pkg::COS_TABLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tnsg_pkg::cfg_type                 cfg,
   tnsg_req_if.sink                          req_bus,
   output logic                              push_valid,
   input  logic                              push_ready,
   output logic [COS_TABLE_BITS+16:0]        push_data
);
   import tnsg_pkg::*;

   logic [PHASE_BITS-1:0]     phase_ff, phase_in;
   logic [15:0]               lfsr_ff, lfsr_in;
   logic [15:0]               draw1, draw2_src, draw2, noise_val;
   logic [PHASE_BITS-1:0]     step_al, seed_al, phase_cur;
   logic [COS_TABLE_BITS-1:0] idx;
   logic                      burst_load, noise_on, accept;

   assign req_bus.ready = push_ready;
   assign accept        = req_bus.valid && push_ready;

   // LFSR draws: burst load first, then the noise draw
   assign burst_load = !req_bus.mode && req_bus.burst_start;
   assign draw1      = lfsr_next(lfsr_ff);
   assign draw2_src  = burst_load ? draw1 : lfsr_ff;
   assign draw2      = lfsr_next(draw2_src);

   // Align 16-bit turn fractions to the accumulator width
   if (PHASE_BITS >= 16) begin : g_al_wide
      assign step_al = PHASE_BITS'(cfg.phase_step) << (PHASE_BITS - 16);
      assign seed_al = PHASE_BITS'(draw1) << (PHASE_BITS - 16);
   end else begin : g_al_narrow
      assign step_al = cfg.phase_step[15 -: PHASE_BITS];
      assign seed_al = draw1[15 -: PHASE_BITS];
   end

   assign phase_cur = burst_load ? seed_al : phase_ff;

   // Table index from the top of the phase
   if (PHASE_BITS >= COS_TABLE_BITS) begin : g_idx_cut
      assign idx = phase_cur[PHASE_BITS-1 -: COS_TABLE_BITS];
   end else begin : g_idx_pad
      assign idx = COS_TABLE_BITS'(phase_cur) << (COS_TABLE_BITS - PHASE_BITS);
   end

   // Next state of the generators
   always_comb begin
      if (req_bus.mode) begin
         noise_on  = (cfg.silence_noise != '0);
         noise_val = draw1;
         lfsr_in   = noise_on ? draw1 : lfsr_ff;
         phase_in  = phase_ff;
      end else begin
         noise_on  = (cfg.noise_gain != '0);
         noise_val = draw2;
         lfsr_in   = noise_on ? draw2 : draw2_src;
         phase_in  = phase_cur + step_al;
      end
   end

   assign push_valid = req_bus.valid;
   assign push_data  = {req_bus.mode, noise_val, idx};

   // Generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         lfsr_ff  <= LFSR_SEED;
      end else if (accept) begin
         phase_ff <= phase_in;
         lfsr_ff  <= lfsr_in;
      end
   end

endmodule

>>> rtl/tnsg_queue.sv
// ----------------------------------------------------------------------------
// tnsg_queue
// Short FIFO between front and back end.
// ----------------------------------------------------------------------------
module tnsg_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = tnsg_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import tnsg_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> rtl/tnsg_back.sv
// ----------------------------------------------------------------------------
// tnsg_back
// Back end: cosine table lookup, gain multiplies, sum with offset and
// saturation, then byte serialization onto the sample channel.
// ----------------------------------------------------------------------------
module tnsg_back #(
   parameter int COS_TABLE_BITS = tnsg_pkg::COS_TABLE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tnsg_pkg::cfg_type           cfg,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  logic [COS_TABLE_BITS+16:0]  pop_data,
   tnsg_rsp_if.source                  rsp_bus
);
   import tnsg_pkg::*;

   localparam int QW    = COS_TABLE_BITS - 2;
   localparam int QSIZE = 2 ** QW;

   // Quarter-wave tables
   logic [15:0] cos_rom [QSIZE];
   logic [15:0] sin_rom [QSIZE];
   for (genvar i = 0; i < QSIZE; i++) begin : g_rom
      assign cos_rom[i] = quarter_mag(i, COS_TABLE_BITS, 1'b0);
      assign sin_rom[i] = quarter_mag(i, COS_TABLE_BITS, 1'b1);
   end

   // Entry fields
   logic                      e_silent;
   logic [15:0]               e_noise;
   logic [COS_TABLE_BITS-1:0] e_idx;
   logic [1:0]                e_quad;
   logic [QW-1:0]             e_off;
   assign {e_silent, e_noise, e_idx} = pop_data;
   assign e_quad = e_idx[COS_TABLE_BITS-1 -: 2];
   assign e_off  = e_idx[QW-1:0];

   // Stage registers
   logic        a_valid_ff, b_valid_ff, out_valid_ff, out_sel_ff;
   logic [15:0] a_mag_ff, a_noise_ff;
   logic        a_neg_ff, a_silent_ff;
   logic [15:0] b_tone_ff;
   logic [14:0] b_noise_ff;
   logic        b_neg_ff, b_silent_ff;
   logic [7:0]  out_byte0_ff, out_byte1_ff;
   logic        out_two_ff;

   logic        out_free, b_free, a_free;
   logic [30:0] tone_prod, noise_prod;
   logic [14:0] noise_scale;

   // Stall chain
   assign out_free  = !out_valid_ff || (rsp_bus.ready && rsp_bus.last_byte);
   assign b_free    = !b_valid_ff || out_free;
   assign a_free    = !a_valid_ff || b_free;
   assign pop_ready = a_free;

   // Stage A: table lookup
   always_ff @(posedge clock) begin
      if (a_free) begin
         a_neg_ff    <= e_quad[0] ^ e_quad[1];
         a_silent_ff <= e_silent;
         a_noise_ff  <= e_noise;
         if (e_silent) begin
            a_mag_ff <= '0;
         end else if (e_quad[0]) begin
            a_mag_ff <= sin_rom[e_off];
         end else begin
            a_mag_ff <= cos_rom[e_off];
         end
      end
   end

   // Stage B: gain multiplies
   assign noise_scale = a_silent_ff ? cfg.silence_noise : cfg.noise_gain;
   assign tone_prod   = 31'(cfg.tone_gain) * 31'(a_mag_ff);
   assign noise_prod  = 31'(noise_scale) * 31'(a_noise_ff);

   always_ff @(posedge clock) begin
      if (b_free) begin
         b_tone_ff   <= tone_prod[30:15];
         b_noise_ff  <= noise_prod[30:16];
         b_neg_ff    <= a_neg_ff;
         b_silent_ff <= a_silent_ff;
      end
   end

   // Stage C: sum, saturate, byte order
   logic signed [17:0] tone_s, sum_s, lo_s, hi_s, clamp_s;
   logic [15:0]        bits;
   logic               wide, big;
   logic [7:0]         byte0_in, byte1_in;

   assign wide = cfg.format_flags[FMT_WIDE_BIT];
   assign big  = cfg.format_flags[FMT_BIG_BIT];

   always_comb begin
      tone_s = $signed({2'b00, b_tone_ff});
      if (b_neg_ff) begin
         tone_s = -tone_s;
      end
      sum_s = tone_s + $signed({3'b000, b_noise_ff});
      if (!b_silent_ff) begin
         sum_s = sum_s + $signed({3'b000, cfg.tone_offset});
      end
      if (cfg.tone_offset == '0) begin
         lo_s = wide ? -18'sd32768 : -18'sd128;
         hi_s = wide ? 18'sd32767 : 18'sd127;
      end else begin
         lo_s = 18'sd0;
         hi_s = wide ? 18'sd65535 : 18'sd255;
      end
      if (sum_s < lo_s) begin
         clamp_s = lo_s;
      end else if (sum_s > hi_s) begin
         clamp_s = hi_s;
      end else begin
         clamp_s = sum_s;
      end
      bits     = clamp_s[15:0];
      byte0_in = (wide && big) ? bits[15:8] : bits[7:0];
      byte1_in = big ? bits[7:0] : bits[15:8];
   end

   always_ff @(posedge clock) begin
      if (out_free && b_valid_ff) begin
         out_byte0_ff <= byte0_in;
         out_byte1_ff <= byte1_in;
         out_two_ff   <= wide;
      end
   end

   // Valid bits and byte select
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         out_sel_ff   <= 1'b0;
      end else begin
         if (a_free) begin
            a_valid_ff <= pop_valid;
         end
         if (b_free) begin
            b_valid_ff <= a_valid_ff;
         end
         if (out_free) begin
            out_valid_ff <= b_valid_ff;
            out_sel_ff   <= 1'b0;
         end else if (rsp_bus.ready) begin
            out_sel_ff <= 1'b1;
         end
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.sample_byte = out_sel_ff ? out_byte1_ff : out_byte0_ff;
   assign rsp_bus.last_byte   = !out_two_ff || out_sel_ff;

endmodule

>>> rtl/tone_and_noise_sample_generator.sv
// ----------------------------------------------------------------------------
// tone_and_noise_sample_generator
// DDS tone plus LFSR noise sample generator with byte serialization.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus  : one request per sample tick (mode, burst_start). A tone tick
//              adds gain*cos(phase), scaled noise and the offset; a silence
//              tick gives scaled noise only. burst_start (tone) reloads phase.
//   rsp_bus  : one beat per sample byte; last_byte marks the final byte.
//              16-bit format gives two beats, 8-bit format one.
//   csr_*    : write-only registers, written by the user only while the
//              block is idle; the block itself does not enforce this.
// Requests pass the queue, table lookup, multiply, sum/saturate, output reg.
// Throughput: one request per cycle into the front end while the queue has
//   room; the byte output register sets the pace at one byte per cycle
//   while the receiver is ready.
// Reset: phase cleared, LFSR seeded, registers to defaults, pipeline empty.
// Stall: a stalled receiver holds the output byte; the pipeline and the
//   four-entry queue fill, then req_bus.ready drops.
// ----------------------------------------------------------------------------
module tone_and_noise_sample_generator #(
   parameter int PHASE_BITS     = tnsg_pkg::PHASE_BITS_DEF,
   parameter int COS_TABLE_BITS = tnsg_pkg::COS_TABLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   tnsg_req_if.sink                          req_bus,
   tnsg_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [tnsg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tnsg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tnsg_pkg::*;

   localparam int ENTRY_W = COS_TABLE_BITS + 17;

   cfg_type cfg_ff;

   logic               push_valid, push_ready, pop_valid, pop_ready;
   logic [ENTRY_W-1:0] push_data, pop_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step    <= PHASE_STEP_RST;
         cfg_ff.tone_gain     <= TONE_GAIN_RST;
         cfg_ff.noise_gain    <= NOISE_GAIN_RST;
         cfg_ff.silence_noise <= SILENCE_NOISE_RST;
         cfg_ff.tone_offset   <= TONE_OFFSET_RST;
         cfg_ff.format_flags  <= FORMAT_FLAGS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PHASE_STEP:    cfg_ff.phase_step    <= csr_wdata;
            CSR_TONE_GAIN:     cfg_ff.tone_gain     <= csr_wdata[14:0];
            CSR_NOISE_GAIN:    cfg_ff.noise_gain    <= csr_wdata[14:0];
            CSR_SILENCE_NOISE: cfg_ff.silence_noise <= csr_wdata[14:0];
            CSR_TONE_OFFSET:   cfg_ff.tone_offset   <= csr_wdata[14:0];
            CSR_FORMAT_FLAGS:  cfg_ff.format_flags  <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   // Front end
   tnsg_front #(
      .PHASE_BITS     (PHASE_BITS),
      .COS_TABLE_BITS (COS_TABLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Work queue
   tnsg_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back end
   tnsg_back #(
      .COS_TABLE_BITS (COS_TABLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_bus   (rsp_bus)
   );

endmodule
